### sv/assert_macros.svh
// assertion macros used by the mesher core
// no dependencies; take in with `include where assertions are written
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, held off while reset is asserted
`define VFCM_ASSERT_RST(lbl, clk_s, rst_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);

// property checked on every rising edge, reset included
`define VFCM_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

### sv/vfcm_pkg.sv
// shared types, constants and face tables of the voxel face culling mesher
// no dependencies; used by the interfaces and all modules
package vfcm_pkg;

    localparam int CELL_W   = 4;
    localparam int TYPE_W   = 8;
    localparam int VERT_W   = 5;
    localparam int COORD_W  = 7;   // holds any size up to 64 and a wrapped -1
    localparam int FACE_CNT = 6;
    localparam int VTX_CNT  = 6;

    localparam int SIZE_X_DEF = 16;
    localparam int SIZE_Y_DEF = 16;
    localparam int SIZE_Z_DEF = 16;

    localparam logic [TYPE_W-1:0] EMPTY_TYPE   = 8'd0;
    localparam logic [TYPE_W-1:0] SHADE_BASE   = 8'd128;
    localparam logic [TYPE_W-1:0] TOP_EXTRA    = 8'd16;
    localparam logic [TYPE_W-1:0] SPECIAL_TYPE = 8'd2;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_MESH  = 1'b1
    } op_t;

    typedef logic [2:0] face_idx_t;
    typedef logic [2:0] vtx_idx_t;
    typedef logic [FACE_CNT-1:0] face_mask_t;

    localparam face_idx_t FACE_NEG_X = 3'd0;
    localparam face_idx_t FACE_POS_X = 3'd1;
    localparam face_idx_t FACE_NEG_Y = 3'd2;
    localparam face_idx_t FACE_POS_Y = 3'd3;
    localparam face_idx_t FACE_NEG_Z = 3'd4;
    localparam face_idx_t FACE_POS_Z = 3'd5;

    localparam vtx_idx_t LAST_VTX = 3'(VTX_CNT - 1);

    // corner offsets {dx,dy,dz} of the two triangles of each face
    localparam logic [2:0] CORNER_TAB [FACE_CNT][VTX_CNT] = '{
        '{3'b000, 3'b001, 3'b010, 3'b010, 3'b001, 3'b011},
        '{3'b100, 3'b110, 3'b101, 3'b110, 3'b111, 3'b101},
        '{3'b000, 3'b100, 3'b001, 3'b100, 3'b101, 3'b001},
        '{3'b010, 3'b011, 3'b110, 3'b110, 3'b011, 3'b111},
        '{3'b000, 3'b010, 3'b100, 3'b010, 3'b110, 3'b100},
        '{3'b001, 3'b101, 3'b011, 3'b011, 3'b101, 3'b111}
    };

    function automatic logic [2:0] face_corner(face_idx_t f, vtx_idx_t v);
        logic [2:0] c;
        c = 3'b000;
        if (f < 3'(FACE_CNT) && v < 3'(VTX_CNT))
        begin
            c = CORNER_TAB[f][v];
        end
        return c;
    endfunction

    // lowest open face above cur
    function automatic face_idx_t next_face(face_mask_t m, face_idx_t cur);
        face_idx_t r;
        r = cur;
        for (int f = FACE_CNT - 1; f >= 0; f--)
        begin
            if (m[f] && 3'(f) > cur)
            begin
                r = 3'(f);
            end
        end
        return r;
    endfunction

    function automatic face_idx_t first_face(face_mask_t m);
        face_idx_t r;
        r = FACE_NEG_X;
        for (int f = FACE_CNT - 1; f >= 0; f--)
        begin
            if (m[f])
            begin
                r = 3'(f);
            end
        end
        return r;
    endfunction

    function automatic face_idx_t final_face(face_mask_t m);
        face_idx_t r;
        r = FACE_NEG_X;
        for (int f = 0; f < FACE_CNT; f++)
        begin
            if (m[f])
            begin
                r = 3'(f);
            end
        end
        return r;
    endfunction

    function automatic logic [TYPE_W-1:0] face_shade(logic [TYPE_W-1:0] t, face_idx_t f);
        logic [TYPE_W-1:0] s;
        s = t;
        if (f == FACE_NEG_Y)
        begin
            s = (t == SPECIAL_TYPE) ? t + SHADE_BASE - 8'd1 : t + SHADE_BASE;
        end
        else if (f == FACE_POS_Y)
        begin
            s = (t == SPECIAL_TYPE) ? t + SHADE_BASE + TOP_EXTRA : t + SHADE_BASE;
        end
        return s;
    endfunction

endpackage

### sv/vfcm_cmd_if.sv
// command channel: voxel writes and mesh requests
// depends on vfcm_pkg
interface vfcm_cmd_if
    import vfcm_pkg::*;
;
    logic              valid;
    logic              ready;
    op_t               operation;
    logic [CELL_W-1:0] cell_x;
    logic [CELL_W-1:0] cell_y;
    logic [CELL_W-1:0] cell_z;
    logic [TYPE_W-1:0] block_type;

    modport source (output valid, operation, cell_x, cell_y, cell_z, block_type,
                    input ready);
    modport sink (input valid, operation, cell_x, cell_y, cell_z, block_type,
                  output ready);
endinterface

### sv/vfcm_vtx_if.sv
// vertex channel: one mesh vertex per word
// depends on vfcm_pkg
interface vfcm_vtx_if
    import vfcm_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [VERT_W-1:0] vertex_x;
    logic [VERT_W-1:0] vertex_y;
    logic [VERT_W-1:0] vertex_z;
    logic [TYPE_W-1:0] shade;
    logic              last_vertex;

    modport source (output valid, vertex_x, vertex_y, vertex_z, shade, last_vertex,
                    input ready);
    modport sink (input valid, vertex_x, vertex_y, vertex_z, shade, last_vertex,
                  output ready);
endinterface

### sv/vfcm_store.sv
// voxel type memory with one write and one registered read port
// clears itself after reset, one entry a cycle; depends on vfcm_pkg
module vfcm_store
    import vfcm_pkg::*;
#(
    parameter int DEPTH = SIZE_X_DEF * SIZE_Y_DEF * SIZE_Z_DEF,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [TYPE_W-1:0] wr_data,
    input  logic [AW-1:0]     rd_addr,
    output logic [TYPE_W-1:0] rd_data,
    output logic              clearing
);

    logic [TYPE_W-1:0] mem [DEPTH];
    logic [TYPE_W-1:0] rd_data_reg;
    logic              clr_active_reg;
    logic [AW-1:0]     clr_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_active_reg)
        begin
            if (clr_addr_reg == AW'(DEPTH - 1))
            begin
                clr_active_reg <= 1'b0;
            end
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_active_reg)
        begin
            mem[clr_addr_reg] <= EMPTY_TYPE;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data  = rd_data_reg;
    assign clearing = clr_active_reg;

endmodule

### sv/voxel_face_culling_mesher_core.sv
// top level of the voxel face culling mesher
// depends on vfcm_pkg, vfcm_cmd_if, vfcm_vtx_if, vfcm_store and assert_macros.svh
//
// usage
//   cmd carries one word per request: a write stores block_type at cell_x/y/z
//   (ignored outside the chunk), a mesh request names one cell
//   vtx returns six vertices per open face of a non-empty cell, faces in the
//   order -x,+x,-y,+y,-z,+z; last_vertex marks the final vertex of the cell
//   a write gives no word on vtx
//   a mesh request of a non-empty cell holds cmd.ready low for its store reads
//   (the cell and its six neighbours through the single read port),
//   then emits one vertex per cycle unless vtx stalls, up to 36 in all;
//   an empty cell or one outside the chunk keeps it low only for the cell read
//   vtx has one output register; when the receiver stalls, emission waits and
//   the block keeps cmd.ready low until the last vertex is in that register;
//   it takes the next request while that word still waits to be taken
//   after reset the store is cleared to empty one entry per cycle, over all
//   SIZE_X*SIZE_Y*SIZE_Z entries (4096 at default size); cmd.ready stays low
//   during that pass
`include "assert_macros.svh"
module voxel_face_culling_mesher_core
    import vfcm_pkg::*;
#(
    parameter int SIZE_X = SIZE_X_DEF,
    parameter int SIZE_Y = SIZE_Y_DEF,
    parameter int SIZE_Z = SIZE_Z_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    vfcm_cmd_if.sink   cmd,
    vfcm_vtx_if.source vtx
);

    localparam int DEPTH = SIZE_X * SIZE_Y * SIZE_Z;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EMIT
    } state_t;

    typedef logic [COORD_W-1:0] coord_t;

    // linear store index, x major
    function automatic logic [AW-1:0] cell_index(coord_t x, coord_t y, coord_t z);
        logic [31:0] lin;
        lin = (32'(x) * 32'(SIZE_Y) + 32'(y)) * 32'(SIZE_Z) + 32'(z);
        return lin[AW-1:0];
    endfunction

    function automatic logic in_chunk(coord_t x, coord_t y, coord_t z);
        return (x < COORD_W'(SIZE_X)) && (y < COORD_W'(SIZE_Y)) && (z < COORD_W'(SIZE_Z));
    endfunction

    state_t            state_reg;
    logic [2:0]        step_reg;       // store read step: cell, then six neighbours
    logic              inb_reg;        // address read last cycle was inside the chunk
    logic [CELL_W-1:0] cx_reg;
    logic [CELL_W-1:0] cy_reg;
    logic [CELL_W-1:0] cz_reg;
    logic [TYPE_W-1:0] type_reg;
    face_mask_t        mask_reg;       // faces whose neighbour is empty
    face_idx_t         face_reg;
    face_idx_t         last_face_reg;
    vtx_idx_t          vtx_idx_reg;

    logic              vld_reg;
    logic [VERT_W-1:0] vx_reg;
    logic [VERT_W-1:0] vy_reg;
    logic [VERT_W-1:0] vz_reg;
    logic [TYPE_W-1:0] shade_reg;
    logic              last_reg;

    logic              store_clearing;
    logic [TYPE_W-1:0] rd_data;
    logic [AW-1:0]     rd_addr;
    logic              rd_inb;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    coord_t            wx;
    coord_t            wy;
    coord_t            wz;
    coord_t            nx;
    coord_t            ny;
    coord_t            nz;
    logic              accept;
    logic              face_open;
    face_mask_t        mask_now;
    logic              emit_load;
    logic [2:0]        corner;
    logic              at_last;

    assign accept = cmd.valid && cmd.ready;
    assign cmd.ready = (state_reg == ST_IDLE) && !store_clearing;

    // write path straight from the command word
    assign wx      = COORD_W'(cmd.cell_x);
    assign wy      = COORD_W'(cmd.cell_y);
    assign wz      = COORD_W'(cmd.cell_z);
    assign wr_addr = cell_index(wx, wy, wz);
    assign wr_en   = accept && (cmd.operation == OP_WRITE) && in_chunk(wx, wy, wz);

    // neighbour coordinate for this read step; -1 wraps far above any size
    always_comb
    begin
        nx = COORD_W'(cx_reg);
        ny = COORD_W'(cy_reg);
        nz = COORD_W'(cz_reg);
        unique case (step_reg)
            3'd1:    nx = nx - 1'b1;
            3'd2:    nx = nx + 1'b1;
            3'd3:    ny = ny - 1'b1;
            3'd4:    ny = ny + 1'b1;
            3'd5:    nz = nz - 1'b1;
            3'd6:    nz = nz + 1'b1;
            default: ;
        endcase
    end

    assign rd_inb  = in_chunk(nx, ny, nz);
    assign rd_addr = cell_index(nx, ny, nz);

    // data back now belongs to step_reg-1; steps 2..7 are faces 0..5
    assign face_open = !inb_reg || (rd_data == EMPTY_TYPE);

    always_comb
    begin
        for (int f = 0; f < FACE_CNT; f++)
        begin
            mask_now[f] = mask_reg[f] || (face_open && (step_reg == 3'(f + 2)));
        end
    end

    assign emit_load = (state_reg == ST_EMIT) && (!vld_reg || vtx.ready);
    assign corner    = face_corner(face_reg, vtx_idx_reg);
    assign at_last   = (face_reg == last_face_reg) && (vtx_idx_reg == LAST_VTX);

    vfcm_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (cmd.block_type),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .clearing (store_clearing)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            inb_reg       <= 1'b0;
            mask_reg      <= '0;
            face_reg      <= FACE_NEG_X;
            last_face_reg <= FACE_NEG_X;
            vtx_idx_reg   <= '0;
            vld_reg       <= 1'b0;
        end
        else
        begin
            // output register
            if (emit_load)
            begin
                vld_reg   <= 1'b1;
                vx_reg    <= VERT_W'(cx_reg) + VERT_W'(corner[2]);
                vy_reg    <= VERT_W'(cy_reg) + VERT_W'(corner[1]);
                vz_reg    <= VERT_W'(cz_reg) + VERT_W'(corner[0]);
                shade_reg <= face_shade(type_reg, face_reg);
                last_reg  <= at_last;
            end
            else if (vtx.ready)
            begin
                vld_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept && cmd.operation == OP_MESH)
                    begin
                        state_reg <= ST_READ;
                        step_reg  <= '0;
                        mask_reg  <= '0;
                        cx_reg    <= cmd.cell_x;
                        cy_reg    <= cmd.cell_y;
                        cz_reg    <= cmd.cell_z;
                    end
                end
                ST_READ:
                begin
                    step_reg <= step_reg + 1'b1;
                    inb_reg  <= rd_inb;
                    if (step_reg == 3'd1)
                    begin
                        // the cell itself; empty or outside means no mesh
                        if (face_open)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        type_reg <= rd_data;
                    end
                    else if (step_reg != 3'd0)
                    begin
                        mask_reg <= mask_now;
                        if (step_reg == 3'd7)
                        begin
                            state_reg     <= (mask_now == '0) ? ST_IDLE : ST_EMIT;
                            face_reg      <= first_face(mask_now);
                            last_face_reg <= final_face(mask_now);
                            vtx_idx_reg   <= '0;
                        end
                    end
                end
                ST_EMIT:
                begin
                    if (emit_load)
                    begin
                        if (vtx_idx_reg == LAST_VTX)
                        begin
                            vtx_idx_reg <= '0;
                            if (face_reg == last_face_reg)
                            begin
                                state_reg <= ST_IDLE;
                            end
                            else
                            begin
                                face_reg <= next_face(mask_reg, face_reg);
                            end
                        end
                        else
                        begin
                            vtx_idx_reg <= vtx_idx_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign vtx.valid       = vld_reg;
    assign vtx.vertex_x    = vx_reg;
    assign vtx.vertex_y    = vy_reg;
    assign vtx.vertex_z    = vz_reg;
    assign vtx.shade       = shade_reg;
    assign vtx.last_vertex = last_reg;

    // a mesh request keeps the block busy on the next cycle
    `VFCM_ASSERT_RST(a_busy_after_mesh, clk, rst_n,
        ((accept && cmd.operation == OP_MESH) |=> !cmd.ready),
        "mesh request did not make the block busy")
    // emission only walks open faces
    `VFCM_ASSERT_RST(a_emit_open_face, clk, rst_n,
        ((state_reg == ST_EMIT) |-> mask_reg[face_reg]),
        "emitting a hidden face")
    // loading the marked vertex ends the mesh
    `VFCM_ASSERT_RST(a_last_ends_mesh, clk, rst_n,
        ((emit_load && at_last) |=> (state_reg == ST_IDLE)),
        "mesh continued after last vertex")
    // a cell outside the chunk is never meshed
    `VFCM_ASSERT_RST(a_outside_no_mesh, clk, rst_n,
        ((state_reg == ST_READ && step_reg == 3'd1 && !inb_reg) |=> (state_reg == ST_IDLE)),
        "cell outside the chunk was meshed")

endmodule

### tb/mesh_vertex_checker.sv
`timescale 1ns / 100ps
// vertex checker for the voxel face culling mesher: mirrors the voxel store,
// predicts the vertices of every mesh request and compares the vertex channel
// depends on vfcm_pkg, vfcm_cmd_if and vfcm_vtx_if
module mesh_vertex_checker
    import vfcm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    vfcm_cmd_if  cmd,
    vfcm_vtx_if  vtx,
    output int   error_count,
    output int   vertices_due
);

    typedef struct packed {
        logic [VERT_W-1:0] vx;
        logic [VERT_W-1:0] vy;
        logic [VERT_W-1:0] vz;
        logic [TYPE_W-1:0] shade;
        logic              last_vertex;
    } mesh_vertex_t;

    // corner offsets {dx,dy,dz}, two triangles per face, faces -x,+x,-y,+y,-z,+z
    localparam logic [2:0] FACE_CORNERS [FACE_CNT][VTX_CNT] = '{
        '{3'b000, 3'b001, 3'b010, 3'b010, 3'b001, 3'b011},
        '{3'b100, 3'b110, 3'b101, 3'b110, 3'b111, 3'b101},
        '{3'b000, 3'b100, 3'b001, 3'b100, 3'b101, 3'b001},
        '{3'b010, 3'b011, 3'b110, 3'b110, 3'b011, 3'b111},
        '{3'b000, 3'b010, 3'b100, 3'b010, 3'b110, 3'b100},
        '{3'b001, 3'b101, 3'b011, 3'b011, 3'b101, 3'b111}
    };

    logic [TYPE_W-1:0] voxel_map [SIZE_X_DEF][SIZE_Y_DEF][SIZE_Z_DEF];
    mesh_vertex_t      expected_vertices [$];

    // cells outside the chunk read as empty
    function automatic logic [TYPE_W-1:0] type_at(int x, int y, int z);
        if (x < 0 || x >= SIZE_X_DEF || y < 0 || y >= SIZE_Y_DEF ||
            z < 0 || z >= SIZE_Z_DEF)
        begin
            return EMPTY_TYPE;
        end
        return voxel_map[x][y][z];
    endfunction

    task automatic predict_mesh(int x, int y, int z);
        logic [TYPE_W-1:0] t;
        logic [TYPE_W-1:0] sh;
        logic [2:0]        c;
        face_mask_t        open_faces;
        face_idx_t         fi;
        int                final_open;
        int                dx;
        int                dy;
        int                dz;
        mesh_vertex_t      v;
        t = type_at(x, y, z);
        if (t == EMPTY_TYPE)
        begin
            return;
        end
        open_faces = '0;
        final_open = -1;
        for (int f = 0; f < FACE_CNT; f++)
        begin
            fi = face_idx_t'(f);
            dx = (fi == FACE_NEG_X) ? -1 : (fi == FACE_POS_X) ? 1 : 0;
            dy = (fi == FACE_NEG_Y) ? -1 : (fi == FACE_POS_Y) ? 1 : 0;
            dz = (fi == FACE_NEG_Z) ? -1 : (fi == FACE_POS_Z) ? 1 : 0;
            if (type_at(x + dx, y + dy, z + dz) == EMPTY_TYPE)
            begin
                open_faces[f] = 1'b1;
                final_open    = f;
            end
        end
        for (int f = 0; f < FACE_CNT; f++)
        begin
            if (!open_faces[f])
            begin
                continue;
            end
            fi = face_idx_t'(f);
            // bottom and top faces get the shade offset, wrapping in 8 bits
            if (fi == FACE_NEG_Y)
            begin
                sh = (t == SPECIAL_TYPE) ? t + SHADE_BASE - 8'd1 : t + SHADE_BASE;
            end
            else if (fi == FACE_POS_Y)
            begin
                sh = (t == SPECIAL_TYPE) ? t + SHADE_BASE + TOP_EXTRA : t + SHADE_BASE;
            end
            else
            begin
                sh = t;
            end
            for (int vi = 0; vi < VTX_CNT; vi++)
            begin
                c             = FACE_CORNERS[f][vi];
                v.vx          = VERT_W'(x + c[2]);
                v.vy          = VERT_W'(y + c[1]);
                v.vz          = VERT_W'(z + c[0]);
                v.shade       = sh;
                v.last_vertex = (f == final_open) && (vi == VTX_CNT - 1);
                expected_vertices.push_back(v);
            end
        end
    endtask

    task automatic check_vertex();
        mesh_vertex_t got;
        mesh_vertex_t want;
        got.vx          = vtx.vertex_x;
        got.vy          = vtx.vertex_y;
        got.vz          = vtx.vertex_z;
        got.shade       = vtx.shade;
        got.last_vertex = vtx.last_vertex;
        if (expected_vertices.size() == 0)
        begin
            error_count++;
            if (error_count <= 10)
            begin
                $display("%t: unexpected vertex (%0d,%0d,%0d) shade %0d last %0b",
                         $realtime, got.vx, got.vy, got.vz, got.shade, got.last_vertex);
            end
        end
        else
        begin
            want = expected_vertices.pop_front();
            if (got.vx !== want.vx || got.vy !== want.vy || got.vz !== want.vz ||
                got.shade !== want.shade || got.last_vertex !== want.last_vertex)
            begin
                error_count++;
                if (error_count <= 10)
                begin
                    $display("%t: vertex mismatch exp (%0d,%0d,%0d) shade %0d last %0b",
                             $realtime, want.vx, want.vy, want.vz, want.shade,
                             want.last_vertex);
                    $display("%t:                 got (%0d,%0d,%0d) shade %0d last %0b",
                             $realtime, got.vx, got.vy, got.vz, got.shade,
                             got.last_vertex);
                end
            end
        end
    endtask

    // outgoing vertices first: a request taken on this edge cannot emit on it
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (voxel_map[i, j, k])
            begin
                voxel_map[i][j][k] = EMPTY_TYPE;
            end
            expected_vertices.delete();
            vertices_due = 0;
        end
        else
        begin
            if (vtx.valid && vtx.ready)
            begin
                check_vertex();
            end
            if (cmd.valid && cmd.ready)
            begin
                if (cmd.operation == OP_WRITE)
                begin
                    voxel_map[cmd.cell_x][cmd.cell_y][cmd.cell_z] = cmd.block_type;
                end
                else
                begin
                    predict_mesh(cmd.cell_x, cmd.cell_y, cmd.cell_z);
                end
            end
            vertices_due = expected_vertices.size();
        end
    end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// top of the mesher testbench: clock, reset, command stimulus, vertex back-pressure
// depends on vfcm_pkg, both channel interfaces, the mesher core and mesh_vertex_checker
module testbench
    import vfcm_pkg::*;
;

    logic clk;
    logic rst_n;
    int   error_count;
    int   vertices_due;
    int   words_sent;
    // set for the tail of the run: sender and receiver stop idling
    logic calm_tail;

    vfcm_cmd_if cmd_ch ();
    vfcm_vtx_if vtx_ch ();

    voxel_face_culling_mesher_core u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .vtx   (vtx_ch)
    );

    mesh_vertex_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd_ch),
        .vtx          (vtx_ch),
        .error_count  (error_count),
        .vertices_due (vertices_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop; far beyond the slowest correct run, which includes the store
    // clear after reset and mesh requests under full back-pressure
    initial
    begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // one command word; returns after the handshake, sometimes followed by a gap
    task automatic send_word(op_t op, logic [CELL_W-1:0] x, logic [CELL_W-1:0] y,
                             logic [CELL_W-1:0] z, logic [TYPE_W-1:0] bt);
        cmd_ch.valid      <= 1'b1;
        cmd_ch.operation  <= op;
        cmd_ch.cell_x     <= x;
        cmd_ch.cell_y     <= y;
        cmd_ch.cell_z     <= z;
        cmd_ch.block_type <= bt;
        @(posedge clk);
        // ready drops for the store clear and for every mesh request
        while (!cmd_ch.ready)
        begin
            @(posedge clk);
        end
        words_sent++;
        if (!calm_tail && $urandom_range(0, 4) == 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
    endtask

    task automatic write_cell(int x, int y, int z, logic [TYPE_W-1:0] bt);
        send_word(OP_WRITE, CELL_W'(x), CELL_W'(y), CELL_W'(z), bt);
    endtask

    // block_type is ignored on a mesh request, so it carries random junk
    task automatic mesh_cell(int x, int y, int z);
        send_word(OP_MESH, CELL_W'(x), CELL_W'(y), CELL_W'(z), TYPE_W'($urandom));
    endtask

    // receiver: bursts of stall between runs of ready, none in the tail
    initial
    begin
        vtx_ch.ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (!calm_tail && $urandom_range(0, 3) == 0)
            begin
                vtx_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
            vtx_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    initial
    begin
        int ox;
        int oy;
        int oz;
        int mode;
        int kind;
        int random_goal;
        logic [TYPE_W-1:0] bt;

        words_sent = 0;
        calm_tail  = 1'b0;
        rst_n             <= 1'b0;
        cmd_ch.valid      <= 1'b0;
        cmd_ch.operation  <= OP_WRITE;
        cmd_ch.cell_x     <= '0;
        cmd_ch.cell_y     <= '0;
        cmd_ch.cell_z     <= '0;
        cmd_ch.block_type <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        // empty cell right after reset: no vertices
        mesh_cell(0, 0, 0);
        // lone voxel in the low corner: all six faces open, outside counts empty
        write_cell(0, 0, 0, 8'd1);
        mesh_cell(0, 0, 0);
        // high corner, top type: shades on -y/+y wrap past 255
        write_cell(15, 15, 15, 8'd255);
        mesh_cell(15, 15, 15);
        // the special type gets its own bottom and top shade
        write_cell(7, 7, 7, SPECIAL_TYPE);
        mesh_cell(7, 7, 7);
        // type 128 on top of it: its shaded faces wrap to zero
        write_cell(7, 8, 7, 8'd128);
        mesh_cell(7, 7, 7);
        mesh_cell(7, 8, 7);
        // close the remaining neighbors: the center is fully hidden
        write_cell(6, 7, 7, 8'd3);
        write_cell(8, 7, 7, 8'd4);
        write_cell(7, 6, 7, 8'd5);
        write_cell(7, 7, 6, 8'd6);
        write_cell(7, 7, 8, 8'd7);
        mesh_cell(7, 7, 7);
        // erasing with type 0 makes the cell empty again
        write_cell(0, 0, 0, EMPTY_TYPE);
        mesh_cell(0, 0, 0);
        write_cell(15, 0, 15, 8'd127);
        mesh_cell(15, 0, 15);
        write_cell(8, 15, 0, SPECIAL_TYPE);
        mesh_cell(8, 15, 0);

        // random part: writes and meshes clustered in a small box so that
        // neighbors are often filled, plus sweeps and some uniform noise
        random_goal = words_sent + 250;
        ox = $urandom_range(0, 12);
        oy = $urandom_range(0, 12);
        oz = $urandom_range(0, 12);
        while (words_sent < random_goal)
        begin
            if (words_sent >= random_goal - 50)
            begin
                calm_tail = 1'b1;
            end
            if ($urandom_range(0, 15) == 0)
            begin
                ox = $urandom_range(0, 12);
                oy = $urandom_range(0, 12);
                oz = $urandom_range(0, 12);
            end
            mode = $urandom_range(0, 9);
            if (mode <= 4)
            begin
                kind = $urandom_range(0, 7);
                if (kind == 0)
                begin
                    bt = EMPTY_TYPE;
                end
                else if (kind == 1)
                begin
                    bt = SPECIAL_TYPE;
                end
                else
                begin
                    bt = TYPE_W'($urandom_range(1, 255));
                end
                write_cell(ox + $urandom_range(0, 3), oy + $urandom_range(0, 3),
                           oz + $urandom_range(0, 3), bt);
            end
            else if (mode <= 7)
            begin
                mesh_cell(ox + $urandom_range(0, 3), oy + $urandom_range(0, 3),
                          oz + $urandom_range(0, 3));
            end
            else if (mode == 8)
            begin
                send_word(op_t'($urandom_range(0, 1)), CELL_W'($urandom_range(0, 15)),
                          CELL_W'($urandom_range(0, 15)), CELL_W'($urandom_range(0, 15)),
                          TYPE_W'($urandom_range(0, 255)));
            end
            else
            begin
                // sweep a 2x2x2 box in x,y,z order, as a mesh builder would
                for (int sx = 0; sx < 2; sx++)
                begin
                    for (int sy = 0; sy < 2; sy++)
                    begin
                        for (int sz = 0; sz < 2; sz++)
                        begin
                            mesh_cell(ox + sx, oy + sy, oz + sz);
                        end
                    end
                end
            end
        end
        cmd_ch.valid <= 1'b0;
        @(posedge clk);

        // drain: wait for every predicted vertex, then watch for strays
        while (vertices_due != 0)
        begin
            @(posedge clk);
        end
        repeat (60) @(posedge clk);
        if (error_count == 0 && vertices_due == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
